FILE: hw/rtl/crc_checked_frame_receiver_defines.svh
// Assertion macros for the checker file of the frame receiver.
// No dependencies; include by bare file name.
`ifndef CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define CRCFR_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define CRCFR_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define CRCFR_ASSERT_NXT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/crcfr_pkg.sv
// Shared types, constants and the CRC byte update for the frame receiver.
// No dependencies.
package crcfr_pkg;

  localparam int BUF_DEPTH = 1024;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W     = 17;

  localparam logic [7:0]       HDR_BYTE       = 8'hFF;
  localparam logic [15:0]      CRC_POLY       = 16'h8408;
  localparam logic [15:0]      CRC_INIT       = 16'hFFFF;
  localparam logic [SUM_W-1:0] FRAME_OVERHEAD = SUM_W'(10);

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_IDLE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_BOOT    = 2'd1,
    VERDICT_OK      = 2'd2,
    VERDICT_CRC_ERR = 2'd3
  } verdict_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } item_t;

  // a registered word leaving the input stage
  typedef struct packed {
    logic  fire;
    item_t item;
  } issue_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
  } result_t;

  // reflected CRC-16/X-25, one byte, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/crcfr_in_if.sv
// Input word channel: valid/ready with command and received byte.
// Depends on nothing.
interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

FILE: hw/rtl/crcfr_out_if.sv
// Result word channel: valid/ready with verdict and captured fields.
// Depends on nothing.
interface crcfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [7:0]  command_code;
  logic [15:0] payload_length;

  modport source (output valid, output verdict, output command_code,
                  output payload_length, input ready);
  modport sink   (input valid, input verdict, input command_code,
                  input payload_length, output ready);
endinterface

FILE: hw/rtl/crcfr_cfg_if.sv
// Configuration write channel: valid/ready with the boot code write data.
// Depends on nothing.
interface crcfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/crcfr_in_stage.sv
// Input register of the frame receiver; issues one word to the tracker.
// Depends on crcfr_pkg.
module crcfr_in_stage
  import crcfr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  item_t  item_in,
  input  logic   out_free,
  output issue_t issue
);

  logic  s1_valid;
  item_t s1_item;
  logic  fire;

  // a byte never waits; an idle word needs room in the result register
  assign fire       = s1_valid && ((s1_item.cmd == CMD_BYTE) || out_free);
  assign item_ready = !s1_valid || fire;
  assign issue      = '{fire: fire, item: s1_item};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item_in;
    end
  end

endmodule

FILE: hw/rtl/crcfr_frame_track.sv
// Frame state, running CRC, boot code register and verdict logic.
// Depends on crcfr_pkg.
module crcfr_frame_track
  import crcfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  issue_t     issue,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       load,
  output result_t    res
);

  logic [7:0]       enter_boot_code;
  logic [CNT_W-1:0] byte_count;
  logic             header_good;
  logic [15:0]      length_word;
  logic [7:0]       command_byte;
  logic [15:0]      crc_accum;
  logic [15:0]      holdback_bytes;

  logic             is_byte;
  logic             is_idle;
  logic             full;
  logic             len_match;
  logic [7:0]       b;
  logic [15:0]      final_crc;
  verdict_t         verdict;

  assign cfg_ready = 1'b1;
  assign b         = issue.item.data_byte;
  assign is_byte   = issue.fire && (issue.item.cmd == CMD_BYTE);
  assign is_idle   = issue.fire && (issue.item.cmd == CMD_IDLE);
  assign full      = (byte_count == CNT_W'(BUF_DEPTH));
  assign len_match = (SUM_W'(byte_count) == ({1'b0, length_word} + FRAME_OVERHEAD));
  assign final_crc = ~crc_accum;

  always_comb begin
    verdict = VERDICT_NONE;
    if (header_good && len_match) begin
      if (final_crc != holdback_bytes) begin
        verdict = VERDICT_CRC_ERR;
      end else if (command_byte == enter_boot_code) begin
        verdict = VERDICT_BOOT;
      end else begin
        verdict = VERDICT_OK;
      end
    end
  end

  assign load = is_idle;
  assign res  = '{verdict: verdict, command_code: command_byte,
                  payload_length: length_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_boot_code <= 8'h00;
    end else if (cfg_valid) begin
      enter_boot_code <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || is_idle) begin
      byte_count     <= '0;
      header_good    <= 1'b1;
      length_word    <= 16'h0000;
      command_byte   <= 8'h00;
      crc_accum      <= CRC_INIT;
      holdback_bytes <= 16'h0000;
    end else if (is_byte) begin
      if (full) begin
        header_good <= 1'b0;
      end else begin
        if ((byte_count == CNT_W'(0) || byte_count == CNT_W'(1)) && b != HDR_BYTE) begin
          header_good <= 1'b0;
        end
        if (byte_count == CNT_W'(6)) begin
          length_word[15:8] <= b;
        end
        if (byte_count == CNT_W'(7)) begin
          length_word[7:0] <= b;
        end
        if (byte_count == CNT_W'(8)) begin
          command_byte <= b;
        end
        // the byte two places back leaves the holdback and enters the CRC
        if (byte_count >= CNT_W'(4)) begin
          crc_accum <= crc_feed(crc_accum, holdback_bytes[15:8]);
        end
        holdback_bytes <= {holdback_bytes[7:0], b};
        byte_count     <= byte_count + CNT_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/crcfr_out_stage.sv
// Result register of the frame receiver with valid/ready hand-off.
// Depends on crcfr_pkg.
module crcfr_out_stage
  import crcfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t res_out,
  output logic    out_free
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      res_out <= res_in;
    end
  end

endmodule

FILE: hw/rtl/crc_checked_frame_receiver.sv
// Top level of the CRC-checked frame receiver.
// Depends on crcfr_pkg, the three channel interfaces and the crcfr_* stages.
//
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+-------------
//  item     | in  | cmd (byte / idle), data_byte             | valid, ready
//  result   | out | verdict, command_code, payload_length    | valid, ready
//  cfg      | in  | data (enter boot code)                   | valid, ready
//
// Each word is held in the input register. The frame tracker acts on it
// combinationally, and its state update lands at the edge on which the word
// leaves that register, where an idle word's verdict is loaded into the
// result register, which must have room for the idle word to leave.
// One word per cycle is sustained: received bytes are never held, and only
// an idle word waits while the result register is still full. Reset clears
// the frame state, the boot code and both valids.
// Config writes are always taken (ready tied high).
module crc_checked_frame_receiver
  import crcfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  crcfr_in_if.sink         item,
  crcfr_out_if.source      result,
  crcfr_cfg_if.sink        cfg
);

  item_t   item_word;
  issue_t  issue;
  logic    out_free;
  logic    load;
  result_t res_next;
  result_t res_reg;

  assign item_word = '{cmd: item.cmd, data_byte: item.data_byte};

  // hold the incoming word in the input register; drop nothing
  crcfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_in    (item_word),
    .out_free   (out_free),
    .issue      (issue)
  );

  // advance the frame state; on idle, form the verdict and clear the frame
  crcfr_frame_track u_track (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_data  (cfg.data),
    .load      (load),
    .res       (res_next)
  );

  // park the verdict until the sink takes it
  crcfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .res_in    (res_next),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .res_out   (res_reg),
    .out_free  (out_free)
  );

  assign result.verdict        = res_reg.verdict;
  assign result.command_code   = res_reg.command_code;
  assign result.payload_length = res_reg.payload_length;

endmodule

FILE: hw/rtl/crcfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
// Depends on crcfr_pkg and crc_checked_frame_receiver_defines.svh.
`include "crc_checked_frame_receiver_defines.svh"

module crcfr_checker
  import crcfr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_verdict,
  input logic [7:0]  res_command_code,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_data
);

  logic [7:0] boot_code_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_code_seen <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      boot_code_seen <= cfg_data;
    end
  end

  `CRCFR_ASSERT_NXT_ALWAYS(a_reset_empties, clk, rst, !res_valid, "result valid after reset")
  `CRCFR_ASSERT_IMP(a_boot_code, clk, rst, res_valid && res_verdict == VERDICT_BOOT, res_command_code == boot_code_seen, "boot verdict without matching code")
  `CRCFR_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_verdict), "stalled result changed")
  `CRCFR_ASSERT_IMP(a_cfg_open, clk, rst, 1'b1, cfg_ready, "config port refused a write")

endmodule

bind crc_checked_frame_receiver crcfr_checker u_chk (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .res_verdict      (result.verdict),
  .res_command_code (result.command_code),
  .cfg_valid        (cfg.valid),
  .cfg_ready        (cfg.ready),
  .cfg_data         (cfg.data)
);

FILE: test/crc_checked_frame_receiver_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the CRC-checked frame receiver: directed and random frames.
// Depends on crcfr_pkg, the three channel interfaces and the receiver top level.
module crc_checked_frame_receiver_tb;
  import crcfr_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 8;      // cycles for byte words still in the pipeline
  localparam int RANDOM_WORDS = 200;

  logic clk;
  logic rst;

  crcfr_in_if  item_ch ();
  crcfr_out_if result_ch ();
  crcfr_cfg_if cfg_ch ();

  crc_checked_frame_receiver dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Frame tracker mirror: what the receiver should hold for the frame in progress.
  int          rx_count;
  bit          hdr_ok;
  logic [15:0] len_field;
  logic [7:0]  cmd_capture;
  logic [15:0] crc_reg;
  logic [15:0] tail_bytes;   // last two bytes, older one in the high half
  logic [7:0]  boot_code;

  result_t     expected_verdicts[$];
  logic [7:0]  frame_buf[$];

  int fail_count;
  int cycle_count;
  int words_sent;
  int results_seen;
  int verdict_seen[4];
  bit gaps_on;

  // Reflected CRC-16/X-25, one data bit at a time, LSB first.
  function automatic logic [15:0] x25_step(logic [15:0] acc, logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb  = acc[0] ^ b[k];
      acc = {1'b0, acc[15:1]};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic void clear_frame();
    rx_count    = 0;
    hdr_ok      = 1'b1;
    len_field   = '0;
    cmd_capture = '0;
    crc_reg     = CRC_INIT;
    tail_bytes  = '0;
  endfunction

  // Advance the mirror by one accepted word; an idle word closes the frame and
  // queues the verdict it should produce.
  function automatic void predict_frame_word(logic c, logic [7:0] b);
    result_t r;
    if (c == CMD_BYTE) begin
      if (rx_count >= BUF_DEPTH) begin
        // buffer full: drop the byte and spoil the frame
        hdr_ok = 1'b0;
      end else begin
        if (rx_count < 2 && b != HDR_BYTE) begin
          hdr_ok = 1'b0;
        end
        if (rx_count == 6) begin
          len_field[15:8] = b;
        end
        if (rx_count == 7) begin
          len_field[7:0] = b;
        end
        if (rx_count == 8) begin
          cmd_capture = b;
        end
        // the byte two places back leaves the hold-back and enters the CRC
        if (rx_count >= 4) begin
          crc_reg = x25_step(crc_reg, tail_bytes[15:8]);
        end
        tail_bytes = {tail_bytes[7:0], b};
        rx_count++;
      end
    end else begin
      r.verdict = VERDICT_NONE;
      if (hdr_ok && rx_count == int'(len_field) + int'(FRAME_OVERHEAD)) begin
        if ((crc_reg ^ 16'hFFFF) == tail_bytes) begin
          r.verdict = (cmd_capture == boot_code) ? VERDICT_BOOT : VERDICT_OK;
        end else begin
          r.verdict = VERDICT_CRC_ERR;
        end
      end
      r.command_code   = cmd_capture;
      r.payload_length = len_field;
      expected_verdicts.push_back(r);
      clear_frame();
    end
  endfunction

  // Mostly no gap, sometimes a few cycles, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Build a well-formed frame with the given length field; cmd_val < 0 picks a random command.
  function automatic void make_frame(int len, int cmd_val);
    logic [15:0] ln;
    logic [15:0] crc;
    ln = len[15:0];
    frame_buf.delete();
    frame_buf.push_back(HDR_BYTE);
    frame_buf.push_back(HDR_BYTE);
    repeat (4) frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf.push_back(ln[15:8]);
    frame_buf.push_back(ln[7:0]);
    for (int i = 8; i < len + 8; i++) begin
      if (i == 8 && cmd_val >= 0) begin
        frame_buf.push_back(cmd_val[7:0]);
      end else begin
        frame_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    crc = CRC_INIT;
    for (int i = 2; i < frame_buf.size(); i++) begin
      crc = x25_step(crc, frame_buf[i]);
    end
    crc = ~crc;
    frame_buf.push_back(crc[15:8]);
    frame_buf.push_back(crc[7:0]);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Drive one word from a falling edge, hold it until taken, then maybe drop valid for a while.
  task automatic send_word(logic c, logic [7:0] b);
    int gap;
    item_ch.valid     = 1'b1;
    item_ch.cmd       = c;
    item_ch.data_byte = b;
    do @(posedge clk); while (!item_ch.ready);
    predict_frame_word(c, b);
    words_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) begin
      send_word(CMD_BYTE, frame_buf[i]);
    end
    send_word(CMD_IDLE, 8'($urandom_range(0, 255)));
  endtask

  // Hold the sender until every verdict is back and trailing bytes have settled.
  task automatic drain_results();
    item_ch.valid = 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_boot_code(logic [7:0] v);
    drain_results();
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = v;
    do @(posedge clk); while (!cfg_ch.ready);
    boot_code = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Boot code still at its reset value of zero.
  task automatic test_reset_boot_code();
    gaps_on = 1'b0;
    send_word(CMD_IDLE, 8'h00);
    make_frame(4, 0);
    send_frame();
    make_frame(4, 8'h5A);
    send_frame();
    make_frame(0, -1);
    send_frame();
    send_word(CMD_IDLE, 8'hFF);
  endtask

  task automatic test_frame_errors();
    gaps_on = 1'b1;
    make_frame(3, -1);
    frame_buf[0] = 8'h7F;
    send_frame();
    make_frame(3, -1);
    frame_buf[1] = 8'hFE;
    send_frame();
    make_frame(5, -1);
    frame_buf.push_back(8'h00);
    send_frame();
    make_frame(5, -1);
    void'(frame_buf.pop_back());
    send_frame();
    // truncated frames: cut inside the header, before the length field, and just after the command byte
    make_frame(6, 8'hC3);
    frame_buf = frame_buf[0:0];
    send_frame();
    make_frame(6, 8'hC3);
    frame_buf = frame_buf[0:4];
    send_frame();
    make_frame(6, 8'hC3);
    frame_buf = frame_buf[0:8];
    send_frame();
    make_frame(2, -1);
    frame_buf[6] = 8'h80;
    send_frame();
  endtask

  task automatic test_crc_errors();
    int n;
    gaps_on = 1'b1;
    make_frame(6, -1);
    n = frame_buf.size();
    frame_buf[n-2] = frame_buf[n-2] ^ 8'h80;
    send_frame();
    make_frame(6, -1);
    n = frame_buf.size();
    frame_buf[n-1] = frame_buf[n-1] ^ 8'h01;
    send_frame();
    make_frame(6, -1);
    frame_buf[3] = frame_buf[3] ^ 8'h10;
    send_frame();
    make_frame(6, -1);
    frame_buf[8] = ~frame_buf[8];
    send_frame();
  endtask

  task automatic test_boot_code_setting();
    logic [7:0] v;
    gaps_on = 1'b1;
    write_boot_code(8'hFF);
    make_frame(3, 8'hFF);
    send_frame();
    make_frame(3, 8'hFE);
    send_frame();
    v = 8'($urandom_range(1, 254));
    write_boot_code(v);
    make_frame(1, v);
    send_frame();
    make_frame(1, v ^ 8'h01);
    send_frame();
    write_boot_code(8'h00);
    make_frame(2, 0);
    send_frame();
  endtask

  task automatic test_buffer_limit();
    gaps_on = 1'b1;
    // one byte past a full buffer: the count saturates onto the length match,
    // but the dropped byte spoils the frame
    make_frame(BUF_DEPTH - 10, -1);
    frame_buf.push_back(8'h55);
    send_frame();
    make_frame(4, -1);
    send_frame();
  endtask

  task automatic test_random_traffic();
    int start_words;
    int r;
    int len;
    int k;
    bit drained;
    start_words   = words_sent;
    drained       = 1'b0;
    while (words_sent - start_words < RANDOM_WORDS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 14) : $urandom_range(15, 120);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        make_frame(len, (len > 0 && $urandom_range(0, 2) == 0) ? int'(boot_code) : -1);
      end else if (r < 60) begin
        make_frame(len, -1);
        k = $urandom_range(2, frame_buf.size() - 1);
        frame_buf[k] = frame_buf[k] ^ (8'h01 << $urandom_range(0, 7));
      end else if (r < 70) begin
        make_frame(len, -1);
        frame_buf[$urandom_range(0, 1)] = 8'($urandom_range(0, 254));
      end else if (r < 78) begin
        make_frame(len, -1);
        if ($urandom_range(0, 1) == 0) begin
          void'(frame_buf.pop_back());
        end else begin
          frame_buf.push_back(8'($urandom_range(0, 255)));
        end
      end else if (r < 88) begin
        frame_buf.delete();
        repeat ($urandom_range(0, 20)) frame_buf.push_back(8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        make_frame(len, -1);
        frame_buf = frame_buf[0:$urandom_range(0, frame_buf.size() - 1)];
      end else begin
        write_boot_code(8'($urandom_range(0, 255)));
        continue;
      end
      send_frame();
      // halfway through, hold the sender until the receiver has caught up
      if (!drained && words_sent - start_words >= RANDOM_WORDS / 2) begin
        drain_results();
        drained = 1'b1;
      end
    end
  endtask

  // Sink side: accept results with random stalls, none while gaps are off.
  initial begin : result_sink
    int stall_left;
    stall_left      = 0;
    result_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ch.ready = 1'b0;
        stall_left--;
      end else begin
        result_ch.ready = 1'b1;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Compare each taken result with the oldest verdict waiting.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result word with no closed frame waiting");
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        check_field("verdict", want.verdict, result_ch.verdict);
        check_field("command_code", want.command_code, result_ch.command_code);
        check_field("payload_length", want.payload_length, result_ch.payload_length);
        verdict_seen[want.verdict]++;
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, expected_verdicts.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    gaps_on           = 1'b0;
    item_ch.valid     = 1'b0;
    item_ch.cmd       = CMD_BYTE;
    item_ch.data_byte = 8'h00;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = 8'h00;
    boot_code         = 8'h00;
    fail_count        = 0;
    cycle_count       = 0;
    words_sent        = 0;
    results_seen      = 0;
    clear_frame();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_boot_code();
    test_frame_errors();
    test_crc_errors();
    test_boot_code_setting();
    test_buffer_limit();
    test_random_traffic();

    drain_results();
    $display("%0d words sent, %0d verdicts checked: none %0d, boot %0d, ok %0d, crc error %0d",
             words_sent, results_seen, verdict_seen[VERDICT_NONE], verdict_seen[VERDICT_BOOT],
             verdict_seen[VERDICT_OK], verdict_seen[VERDICT_CRC_ERR]);
    $display("boot codes 0x00, 0xFF and random values; a frame one byte past the buffer");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/crcfr_pkg.sv
hw/rtl/crcfr_in_if.sv
hw/rtl/crcfr_out_if.sv
hw/rtl/crcfr_cfg_if.sv
hw/rtl/crcfr_in_stage.sv
hw/rtl/crcfr_frame_track.sv
hw/rtl/crcfr_out_stage.sv
hw/rtl/crc_checked_frame_receiver.sv
hw/rtl/crcfr_checker.sv
test/crc_checked_frame_receiver_tb.sv
